@@ hdl/fdss_pkg.sv @@
package fdss_pkg;

   // configuration register indexes
   localparam logic CSR_FRAME_BYTES  = 1'b0;
   localparam logic CSR_PREFIX_BYTES = 1'b1;

   localparam logic [8:0]  FRAME_BYTES_RESET  = 9'd256;
   localparam logic [8:0]  PREFIX_BYTES_RESET = 9'd0;

   localparam int          SCORE_W   = 19;
   localparam logic [18:0] SCORE_MAX = 19'h7FFFF;

   localparam int          RSP_DATA_W = 24;

endpackage

@@ hdl/frame_delta_similarity_scorer_core.sv @@
// Channel   Dir  Handshake              Payload
// req_      in   req_tvalid/req_tready  req_tdata[7:0]  = data_byte
// rsp_      out  rsp_tvalid/rsp_tready  rsp_tdata[18:0] = score_q8, rsp_tuser = prefix_match
// csr_      in   csr_valid/csr_ready    csr_index (0 frame_bytes, 1 prefix_bytes), csr_data
//
// A scored byte past the prefix goes from accept to next accept through: accept with
// store read, difference, eight bit-serial weighting steps (one difference bit per cycle
// into the 2*KW-bit accumulator), and frame bookkeeping. Prefix bytes and bytes of the
// first two frames skip the weighting steps.
// The last byte of a scored frame then runs the restoring divider over 2*KW+8 quotient bits
// (one quotient bit per cycle) and loads the result register once it is free.
// Synchronous active-high reset clears control state; the two byte stores are not cleared.
// Requests stall through the divide and while the result register holds an untaken result.
module frame_delta_similarity_scorer_core
   import fdss_pkg::*;
#(
   parameter int MAX_BYTES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [7:0]            req_tdata,   // [7:0] data_byte
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,   // [18:0] score_q8, [23:19] zero
   output logic                  rsp_tuser,   // [0] prefix_match
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic                  csr_index,
   input  logic [8:0]            csr_data
);

   localparam int PW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
   localparam int KW = $clog2(MAX_BYTES * 8 + 1);
   localparam int SW = 2 * KW;
   localparam int DV = SW + 8;
   localparam int CW = $clog2(DV + 1);

   typedef enum logic [2:0] {
      S_IDLE,
      S_CALC,
      S_BITS,
      S_FIN,
      S_DIV,
      S_OUT
   } state_type;

   state_type         state_ff;
   logic [8:0]        frame_bytes_ff;
   logic [8:0]        prefix_bytes_ff;
   logic [PW-1:0]     pos_ff;
   logic [1:0]        frames_ff;
   logic              prefix_ok_ff;
   logic [SW-1:0]     sum_ff;
   logic [7:0]        cur_ff;
   logic [7:0]        rd_frame_ff;
   logic [7:0]        rd_diff_ff;
   logic [7:0]        same_ff;
   logic [KW-1:0]     kbit_ff;
   logic [2:0]        bit_cnt_ff;
   logic [DV-1:0]     dq_ff;
   logic [KW-1:0]     rem_ff;
   logic [CW-1:0]     div_cnt_ff;
   logic              match_ff;
   logic              rsp_valid_ff;
   logic [SCORE_W-1:0] rsp_score_ff;
   logic              rsp_match_ff;

   logic [7:0]        frame_mem [MAX_BYTES];
   logic [7:0]        diff_mem  [MAX_BYTES];

   logic [8:0]        fb;
   logic [8:0]        pb;
   logic [KW-1:0]     nbits;
   logic [7:0]        diff;
   logic              in_prefix;
   logic [KW-1:0]     k_start;
   logic              last_byte;
   logic [SW-1:0]     sum_in;
   logic [KW:0]       trial;
   logic [KW:0]       trial_sub;
   logic [DV-1:0]     dq_in;
   logic [KW-1:0]     rem_in;
   logic [SCORE_W-1:0] score;
   logic              accept;
   logic              slot_free;

   assign accept    = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign csr_ready = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata = {{(RSP_DATA_W - SCORE_W){1'b0}}, rsp_score_ff};
   assign rsp_tuser = rsp_match_ff;
   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (frame_bytes_ff == 9'd0) begin
         fb = 9'd1;
      end else if (32'(frame_bytes_ff) > MAX_BYTES) begin
         fb = 9'(MAX_BYTES);
      end else begin
         fb = frame_bytes_ff;
      end
      pb        = (prefix_bytes_ff > fb) ? fb : prefix_bytes_ff;
      nbits     = KW'({fb, 3'b000});
      diff      = rd_frame_ff ^ cur_ff;
      in_prefix = 32'(pos_ff) < 32'(pb);
      k_start   = KW'((32'(pos_ff) - 32'(pb)) * 8);
      last_byte = (32'(pos_ff) + 1) >= 32'(fb);

      // one weighted bit per cycle, MSB first
      sum_in = sum_ff;
      if (same_ff[7] && (kbit_ff < nbits)) begin
         sum_in = sum_ff + SW'(nbits - kbit_ff);
      end

      // restoring divide step
      trial     = {rem_ff, dq_ff[DV-1]};
      trial_sub = trial - {1'b0, nbits};
      if (trial >= {1'b0, nbits}) begin
         rem_in = trial_sub[KW-1:0];
         dq_in  = {dq_ff[DV-2:0], 1'b1};
      end else begin
         rem_in = trial[KW-1:0];
         dq_in  = {dq_ff[DV-2:0], 1'b0};
      end

      if (!match_ff) begin
         score = '0;
      end else if (dq_ff > DV'(SCORE_MAX)) begin
         score = SCORE_MAX;
      end else begin
         score = dq_ff[SCORE_W-1:0];
      end
   end

   // byte stores, read before write at the same address
   always_ff @(posedge clock) begin
      if (accept) begin
         frame_mem[pos_ff] <= req_tdata;
         rd_frame_ff       <= frame_mem[pos_ff];
         rd_diff_ff        <= diff_mem[pos_ff];
         cur_ff            <= req_tdata;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_CALC && frames_ff != 2'd0) begin
         diff_mem[pos_ff] <= diff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         frame_bytes_ff  <= FRAME_BYTES_RESET;
         prefix_bytes_ff <= PREFIX_BYTES_RESET;
         pos_ff          <= '0;
         frames_ff       <= 2'd0;
         prefix_ok_ff    <= 1'b1;
         sum_ff          <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               CSR_FRAME_BYTES:  frame_bytes_ff  <= csr_data;
               CSR_PREFIX_BYTES: prefix_bytes_ff <= csr_data;
               default: ;
            endcase
         end

         if (state_ff == S_OUT && slot_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  state_ff <= S_CALC;
               end
            end
            S_CALC: begin
               same_ff    <= ~(rd_diff_ff ^ diff);
               kbit_ff    <= k_start;
               bit_cnt_ff <= 3'd0;
               if (frames_ff == 2'd2 && in_prefix) begin
                  if (rd_diff_ff != diff) begin
                     prefix_ok_ff <= 1'b0;
                  end
                  state_ff <= S_FIN;
               end else if (frames_ff == 2'd2) begin
                  state_ff <= S_BITS;
               end else begin
                  state_ff <= S_FIN;
               end
            end
            S_BITS: begin
               sum_ff     <= sum_in;
               same_ff    <= {same_ff[6:0], 1'b0};
               kbit_ff    <= kbit_ff + KW'(1);
               bit_cnt_ff <= bit_cnt_ff + 3'd1;
               if (bit_cnt_ff == 3'd7) begin
                  state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               if (last_byte) begin
                  pos_ff       <= '0;
                  prefix_ok_ff <= 1'b1;
                  sum_ff       <= '0;
                  if (frames_ff == 2'd2) begin
                     match_ff   <= prefix_ok_ff;
                     dq_ff      <= {sum_ff, 8'h00};
                     rem_ff     <= '0;
                     div_cnt_ff <= '0;
                     state_ff   <= S_DIV;
                  end else begin
                     frames_ff <= frames_ff + 2'd1;
                     state_ff  <= S_IDLE;
                  end
               end else begin
                  pos_ff   <= pos_ff + PW'(1);
                  state_ff <= S_IDLE;
               end
            end
            S_DIV: begin
               dq_ff      <= dq_in;
               rem_ff     <= rem_in;
               div_cnt_ff <= div_cnt_ff + CW'(1);
               if (div_cnt_ff == CW'(DV - 1)) begin
                  state_ff <= S_OUT;
               end
            end
            S_OUT: begin
               if (slot_free) begin
                  rsp_score_ff <= score;
                  rsp_match_ff <= match_ff;
                  state_ff     <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

@@ tb/tb_frame_delta_similarity_scorer_core.sv @@
`timescale 1ns / 1ps

module tb_frame_delta_similarity_scorer_core;
   import fdss_pkg::*;

   localparam int MAX_BYTES   = 256;
   localparam int ITEM_TARGET = 1900;
   // request pipeline plus a full divider pass, with margin
   localparam int SETTLE      = 150;

   typedef struct packed {
      logic [SCORE_W-1:0] score_q8;
      logic               prefix_match;
   } score_type;

   typedef enum logic [1:0] {ROW_BYTE, ROW_FRAME_BYTES, ROW_PREFIX_BYTES} stim_kind_type;

   typedef struct {
      stim_kind_type      kind;
      logic [8:0]         value;
      bit                 typed;
      score_type          res;
   } stim_row_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [7:0]            req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic                  csr_index = CSR_FRAME_BYTES;
   logic [8:0]            csr_data = '0;

   frame_delta_similarity_scorer_core #(.MAX_BYTES(MAX_BYTES)) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // scorer model state
   logic [8:0]  cfg_frame_bytes  = FRAME_BYTES_RESET;
   logic [8:0]  cfg_prefix_bytes = PREFIX_BYTES_RESET;
   logic [7:0]  prev_frame [MAX_BYTES];
   logic [7:0]  prev_diff [MAX_BYTES];
   int          byte_pos     = 0;
   int          frames_seen  = 0;
   bit          prefix_ok    = 1'b1;
   longint      weighted_sum = 0;

   score_type   pending_scores[$];
   int          mismatch_count = 0;
   int          items_sent     = 0;
   int          gap_pct        = 20;
   int          stall_pct      = 70;

   function automatic int eff_frame_bytes();
      if (cfg_frame_bytes == 0) return 1;
      if (cfg_frame_bytes > MAX_BYTES) return MAX_BYTES;
      return cfg_frame_bytes;
   endfunction

   task automatic predict_byte(input logic [7:0] cur, output bit emit, output score_type res);
      int         fb;
      int         pb;
      int         nbits;
      int         pos;
      int         k;
      logic [7:0] diff;
      logic [7:0] same;
      longint     scaled;
      fb    = eff_frame_bytes();
      pb    = (cfg_prefix_bytes > fb) ? fb : cfg_prefix_bytes;
      nbits = fb * 8;
      pos   = (byte_pos >= MAX_BYTES) ? MAX_BYTES - 1 : byte_pos;
      emit  = 1'b0;
      res   = '0;
      if (frames_seen >= 1) begin
         diff = prev_frame[pos] ^ cur;
         if (frames_seen >= 2) begin
            if (pos < pb) begin
               if (prev_diff[pos] != diff) prefix_ok = 1'b0;
            end else begin
               same = ~(prev_diff[pos] ^ diff);
               k    = (pos - pb) * 8;
               // MSB first; bits past the frame end weigh nothing
               for (int j = 0; j < 8; j++) begin
                  if (same[7-j] && (k + j) < nbits) weighted_sum += nbits - (k + j);
               end
            end
         end
         prev_diff[pos] = diff;
      end
      prev_frame[pos] = cur;
      if (pos + 1 >= fb) begin
         if (frames_seen >= 2) begin
            scaled = 0;
            if (prefix_ok) begin
               scaled = (weighted_sum * 256) / nbits;
               if (scaled > SCORE_MAX) scaled = SCORE_MAX;
            end
            res.score_q8     = scaled[SCORE_W-1:0];
            res.prefix_match = prefix_ok;
            emit             = 1'b1;
         end else begin
            frames_seen++;
         end
         byte_pos     = 0;
         prefix_ok    = 1'b1;
         weighted_sum = 0;
      end else begin
         byte_pos = pos + 1;
      end
   endtask

   task automatic send_byte(input logic [7:0] b, input bit typed, input score_type typed_res);
      bit        emit;
      score_type res;
      while ($urandom_range(99) < gap_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= b;
      do @(posedge clock); while (!req_tready);
      predict_byte(b, emit, res);
      if (emit) pending_scores = {pending_scores, (typed ? typed_res : res)};
      items_sent++;
   endtask

   // drain outstanding scores and let the pipeline go quiet
   task automatic settle();
      req_tvalid <= 1'b0;
      while (pending_scores.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [8:0] val);
      settle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_FRAME_BYTES) cfg_frame_bytes = val;
      else cfg_prefix_bytes = val;
   endtask

   // shaped frames keep the difference pattern close to the last one
   task automatic send_frame(input bit shaped);
      int         fb;
      int         pb;
      logic [7:0] noise;
      logic [7:0] b;
      fb = eff_frame_bytes();
      pb = (cfg_prefix_bytes > fb) ? fb : cfg_prefix_bytes;
      for (int i = 0; i < fb; i++) begin
         if (shaped) begin
            if (byte_pos < pb) begin
               noise = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'h00;
            end else begin
               noise = ($urandom_range(2) == 0) ? 8'($urandom & $urandom) : 8'h00;
            end
            b = prev_frame[byte_pos] ^ prev_diff[byte_pos] ^ noise;
         end else begin
            b = 8'($urandom_range(255));
         end
         send_byte(b, 1'b0, '0);
      end
   endtask

   function automatic stim_row_type stim_row(stim_kind_type kind, logic [8:0] value, bit typed,
                                             logic [SCORE_W-1:0] score, logic match);
      stim_row_type r;
      r.kind             = kind;
      r.value            = value;
      r.typed            = typed;
      r.res.score_q8     = score;
      r.res.prefix_match = match;
      return r;
   endfunction

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      score_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_scores.size() == 0) begin
            $error("unexpected score: score_q8=%0d prefix_match=%0d",
                   rsp_tdata[SCORE_W-1:0], rsp_tuser);
            mismatch_count++;
         end else begin
            want = pending_scores.pop_front();
            if (rsp_tdata[SCORE_W-1:0] !== want.score_q8) begin
               $error("score_q8: expected %0d, got %0d", want.score_q8, rsp_tdata[SCORE_W-1:0]);
               mismatch_count++;
            end
            if (rsp_tuser !== want.prefix_match) begin
               $error("prefix_match: expected %0d, got %0d", want.prefix_match, rsp_tuser);
               mismatch_count++;
            end
            if (rsp_tdata[RSP_DATA_W-1:SCORE_W] !== '0) begin
               $error("rsp_tdata pad: expected 0, got %0h", rsp_tdata[RSP_DATA_W-1:SCORE_W]);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      #4_000_000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      stim_row_type dir_table[$];
      int        random_start;
      int        span;
      int        fb;
      int        r;
      int        nframes;
      logic [8:0] fb_val;
      logic [8:0] pb_val;

      // frame size 1: a repeated byte gives zero difference twice, then full score
      dir_table = {dir_table, stim_row(ROW_FRAME_BYTES,  9'd0,   0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h00,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h00,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h00,  1, 19'd1152, 1)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'hFF,  1, 19'd0, 1)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'hFF,  1, 19'd0, 1)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'hFF,  1, 19'd1152, 1)};
      // prefix longer than the frame clamps; whole frame is prefix
      dir_table = {dir_table, stim_row(ROW_PREFIX_BYTES, 9'd511, 0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'hFF,  1, 19'd0, 1)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h5A,  1, 19'd0, 0)};
      dir_table = {dir_table, stim_row(ROW_FRAME_BYTES,  9'd4,   0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_PREFIX_BYTES, 9'd256, 0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h5A,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h00,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h80,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h7F,  1, 19'd0, 0)};
      // shrink mid-frame: next byte closes the frame, late bits weigh nothing
      dir_table = {dir_table, stim_row(ROW_PREFIX_BYTES, 9'd0,   0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h11,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h22,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h33,  0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_FRAME_BYTES,  9'd1,   0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_BYTE,         9'h44,  0, 0, 0)};
      // two-byte frames, one prefix byte: third identical frame scores 1600
      dir_table = {dir_table, stim_row(ROW_FRAME_BYTES,  9'd2,   0, 0, 0)};
      dir_table = {dir_table, stim_row(ROW_PREFIX_BYTES, 9'd1,   0, 0, 0)};
      for (int n = 0; n < 3; n++) begin
         dir_table = {dir_table, stim_row(ROW_BYTE, 9'h3C, 0, 0, 0)};
         dir_table = {dir_table, stim_row(ROW_BYTE, 9'hC3, n == 2, 19'd1600, 1)};
      end

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: two silent 256-byte frames fill both stores, third scores
      for (int n = 0; n < 3 * MAX_BYTES; n++) send_byte(8'($urandom_range(255)), 1'b0, '0);

      foreach (dir_table[i]) begin
         case (dir_table[i].kind)
            ROW_BYTE: begin
               send_byte(dir_table[i].value[7:0], dir_table[i].typed, dir_table[i].res);
            end
            ROW_FRAME_BYTES: begin
               write_csr(CSR_FRAME_BYTES, dir_table[i].value);
            end
            default: begin
               write_csr(CSR_PREFIX_BYTES, dir_table[i].value);
            end
         endcase
      end

      random_start = items_sent;
      span         = ITEM_TARGET - random_start;
      while (items_sent < ITEM_TARGET) begin
         case ((items_sent - random_start) * 3 / span)
            0: begin
               gap_pct   = 20;
               stall_pct = 70;
            end
            1: begin
               gap_pct   = 70;
               stall_pct = 20;
            end
            default: begin
               gap_pct   = 0;
               stall_pct = 0;
            end
         endcase

         r = $urandom_range(99);
         if (r < 1) fb_val = 9'(256 + $urandom_range(255));
         else if (r < 4) fb_val = 9'd0;
         else if (r < 14) fb_val = 9'($urandom_range(64, 17));
         else fb_val = 9'($urandom_range(16, 1));
         write_csr(CSR_FRAME_BYTES, fb_val);
         fb = eff_frame_bytes();

         r = $urandom_range(99);
         if (r < 30) pb_val = 9'd0;
         else if (r < 80) pb_val = 9'($urandom_range(fb, 0));
         else if (r < 90) pb_val = 9'(fb);
         else pb_val = 9'($urandom_range(511, fb));
         write_csr(CSR_PREFIX_BYTES, pb_val);

         if (fb <= 16) nframes = $urandom_range(6, 2);
         else if (fb <= 64) nframes = $urandom_range(2, 1);
         else nframes = 1;
         for (int f = 0; f < nframes; f++) send_frame($urandom_range(99) < 70);
      end

      settle();
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
